FILE: rtl/core/bhams_pkg.sv
// bhams_pkg: shared types, codes and defaults for the bitmap heap allocator
// with mark and sweep bookkeeping. no dependencies.
package bhams_pkg;

  localparam int SMALL_SLOTS_DEF  = 256;
  localparam int BIG_GRANULES_DEF = 1024;
  localparam int GRANULE_LOG_DEF  = 5;

  localparam int KIND_W = 2;
  localparam int LEN_W  = 16;
  localparam int ADDR_W = 32;
  localparam int NEED_W = 17;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MARK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SWEEP = 2'd2;

  localparam logic [1:0] REG_BASE8   = 2'd0;
  localparam logic [1:0] REG_BASE16  = 2'd1;
  localparam logic [1:0] REG_BASE32  = 2'd2;
  localparam logic [1:0] REG_BASEGR  = 2'd3;

  typedef struct packed {
    logic [31:0] marked;
    logic [31:0] used;
  } small_word_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] marked;
    logic [31:0] used;
  } big_word_t;

endpackage

FILE: rtl/core/bitmap_heap_alloc_mark_sweep_unit.sv
// bitmap heap allocator with mark and sweep: bitmaps in two word memories
// (small classes, granules), scanned one 32-bit word per read. uses bhams_pkg.
// steps: allocate reads and checks each small word scanned, then each granule word,
//   bit by bit inside a partly used word, then reads and writes each word of the taken run;
//   mark decodes the address, then checks the slot unless the address is out of range
//   or misaligned; sweep reads and writes each word of both memories. one item at a time, result on
//   result_address/status for one cycle with done, busy low that cycle.
// reset: synchronous; afterwards a clearing pass over both memories holds busy high.
//   the receiver cannot stall.
module bitmap_heap_alloc_mark_sweep_unit #(
  parameter int SMALL_SLOTS  = bhams_pkg::SMALL_SLOTS_DEF,
  parameter int BIG_GRANULES = bhams_pkg::BIG_GRANULES_DEF,
  parameter int GRANULE_LOG  = bhams_pkg::GRANULE_LOG_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic [bhams_pkg::KIND_W-1:0]  kind,
  input  logic [bhams_pkg::LEN_W-1:0]   length_bytes,
  input  logic [bhams_pkg::ADDR_W-1:0]  address,
  output logic                          done,
  output logic [bhams_pkg::ADDR_W-1:0]  result_address,
  output logic                          status
);
  import bhams_pkg::*;

  localparam int SW     = (SMALL_SLOTS + 31) / 32;
  localparam int SDEPTH = 3 * SW;
  localparam int BW     = (BIG_GRANULES + 31) / 32;
  localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int BAW    = (BW > 1) ? $clog2(BW) : 1;
  localparam int SWW    = (SW > 1) ? $clog2(SW) : 1;
  localparam int GW     = $clog2(BIG_GRANULES);
  localparam int CMAX   = (SDEPTH > BW) ? SDEPTH : BW;
  localparam int CW     = $clog2(CMAX + 1);
  localparam logic [31:0] S_PAD = (SMALL_SLOTS % 32 == 0) ? 32'd0 :
                                  ~((32'd1 << (SMALL_SLOTS % 32)) - 32'd1);
  localparam logic [31:0] B_PAD = (BIG_GRANULES % 32 == 0) ? 32'd0 :
                                  ~((32'd1 << (BIG_GRANULES % 32)) - 32'd1);
  localparam logic [32:0] SPAN8  = 33'(SMALL_SLOTS) << 3;
  localparam logic [32:0] SPAN16 = 33'(SMALL_SLOTS) << 4;
  localparam logic [32:0] SPAN32 = 33'(SMALL_SLOTS) << 5;
  localparam logic [32:0] SPANGR = 33'(BIG_GRANULES) << GRANULE_LOG;
  localparam logic [NEED_W-1:0] GMASK = NEED_W'((1 << GRANULE_LOG) - 1);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_S_RD  = 4'd2;
  localparam logic [3:0] ST_S_CHK = 4'd3;
  localparam logic [3:0] ST_B_RD  = 4'd4;
  localparam logic [3:0] ST_B_CHK = 4'd5;
  localparam logic [3:0] ST_B_BIT = 4'd6;
  localparam logic [3:0] ST_B_SRD = 4'd7;
  localparam logic [3:0] ST_B_SWR = 4'd8;
  localparam logic [3:0] ST_M_DEC = 4'd9;
  localparam logic [3:0] ST_M_CHK = 4'd10;
  localparam logic [3:0] ST_W_SRD = 4'd11;
  localparam logic [3:0] ST_W_SWR = 4'd12;
  localparam logic [3:0] ST_W_BRD = 4'd13;
  localparam logic [3:0] ST_W_BWR = 4'd14;

  small_word_t smem [SDEPTH];
  big_word_t   bmem [BW];
  small_word_t s_q;
  big_word_t   b_q;

  logic [3:0]        st;
  logic [31:0]       base8, base16, base32, basegr;
  logic [ADDR_W-1:0] addr_r;
  logic [1:0]        cls;
  logic [SWW-1:0]    sw;
  logic [BAW-1:0]    bw;
  logic [4:0]        bk;
  logic [31:0]       hold;
  logic [NEED_W-1:0] need, run_len;
  logic [GW-1:0]     run_start, e_beg, e_end;
  logic [CW-1:0]     cnt;
  logic              carry;
  logic              m_big;
  logic [SAW-1:0]    m_swa;
  logic [BAW-1:0]    m_bwa;
  logic [4:0]        m_bit;

  // memory port signals
  logic              s_we, b_we;
  logic [SAW-1:0]    s_ra, s_wa;
  logic [BAW-1:0]    b_ra, b_wa;
  small_word_t       s_wd;
  big_word_t         b_wd;

  // mark decode
  logic [31:0]       off_a [4];
  logic              hit_a [4];
  logic [1:0]        msel;
  logic              mhit, maligned;
  logic [31:0]       midx;
  logic [4:0]        mlg;
  logic [SAW-1:0]    dec_swa;
  logic [BAW-1:0]    dec_bwa;

  // scan helpers
  logic [SAW-1:0]    s_cur;
  logic [31:0]       s_uw, b_uw;
  logic [4:0]        s_k;
  logic [NEED_W-1:0] need_c;
  logic [NEED_W:0]   len_plus32, len_plus1;
  logic [GW-1:0]     word_start, bit_pos;
  logic [BAW-1:0]    e_bw, end_bw;
  logic [31:0]       set_mask;
  logic [31:0]       sw_keep, hp, kp, hn, kn;

  assign busy = (st != ST_IDLE);

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      logic [31:0] b;
      logic [32:0] sp;
      b  = (r == 0) ? base8 : (r == 1) ? base16 : (r == 2) ? base32 : basegr;
      sp = (r == 0) ? SPAN8 : (r == 1) ? SPAN16 : (r == 2) ? SPAN32 : SPANGR;
      off_a[r] = addr_r - b;
      hit_a[r] = (addr_r >= b) && ({1'b0, off_a[r]} < sp);
    end
    msel = 2'd3;
    for (int r = 3; r >= 0; r--) begin
      if (hit_a[r]) msel = 2'(r);
    end
    mhit     = hit_a[0] || hit_a[1] || hit_a[2] || hit_a[3];
    mlg      = (msel == 2'd3) ? 5'(GRANULE_LOG) : 5'(3 + msel);
    maligned = (off_a[msel] & ((32'd1 << mlg) - 32'd1)) == 32'd0;
    midx     = off_a[msel] >> mlg;
    dec_swa  = SAW'(32'(msel) * SW + (midx >> 5));
    dec_bwa  = BAW'(midx >> 5);
  end

  always_comb begin
    s_cur  = SAW'(32'(cls) * SW + 32'(sw));
    s_uw   = s_q.used | ((32'(sw) == SW - 1) ? S_PAD : 32'd0);
    s_k    = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (!s_uw[i]) s_k = 5'(i);
    end
    b_uw       = b_q.used | ((32'(bw) == BW - 1) ? B_PAD : 32'd0);
    need_c     = (NEED_W'(length_bytes) + GMASK) >> GRANULE_LOG;
    len_plus32 = {1'b0, run_len} + (NEED_W+1)'(32);
    len_plus1  = {1'b0, run_len} + (NEED_W+1)'(1);
    word_start = GW'({bw, 5'd0});
    bit_pos    = GW'({bw, bk});
    e_bw       = BAW'(e_beg >> 5);
    end_bw     = BAW'(e_end >> 5);
    set_mask   = ((bw == e_bw) ? (32'hffff_ffff << e_beg[4:0]) : 32'hffff_ffff) &
                 ((bw == end_bw) ? (32'hffff_ffff >> (5'd31 - e_end[4:0])) : 32'hffff_ffff);
  end

  // sweep: per-bit keep from the last start at or below it, prefix over 5 levels
  always_comb begin
    hp = b_q.start;
    kp = b_q.marked;
    for (int lv = 0; lv < 5; lv++) begin
      hn = hp;
      kn = kp;
      for (int i = 0; i < 32; i++) begin
        if (i >= (1 << lv) && !hp[i]) begin
          hn[i] = hp[i - (1 << lv)];
          kn[i] = kp[i - (1 << lv)];
        end
      end
      hp = hn;
      kp = kn;
    end
    for (int i = 0; i < 32; i++) begin
      sw_keep[i] = hp[i] ? kp[i] : carry;
    end
  end

  always_comb begin
    s_ra = s_cur;
    b_ra = bw;
    s_we = 1'b0;
    b_we = 1'b0;
    s_wa = s_cur;
    b_wa = bw;
    s_wd = s_q;
    b_wd = b_q;
    case (st)
      ST_CLEAR: begin
        s_we = (32'(cnt) < SDEPTH);
        b_we = (32'(cnt) < BW);
        s_wa = SAW'(cnt);
        b_wa = BAW'(cnt);
        s_wd = '0;
        b_wd = '0;
      end
      ST_S_CHK: begin
        s_we = (~s_uw != 32'd0);
        s_wd.used = s_q.used | (32'd1 << s_k);
      end
      ST_B_SWR: begin
        b_we = 1'b1;
        b_wd.used  = b_q.used | set_mask;
        b_wd.start = b_q.start | ((bw == e_bw) ? (32'd1 << e_beg[4:0]) : 32'd0);
      end
      ST_M_DEC: begin
        s_ra = dec_swa;
        b_ra = dec_bwa;
      end
      ST_M_CHK: begin
        s_wa = m_swa;
        b_wa = m_bwa;
        s_we = !m_big && s_q.used[m_bit];
        b_we = m_big && b_q.used[m_bit] && b_q.start[m_bit];
        s_wd.marked = s_q.marked | (32'd1 << m_bit);
        b_wd.marked = b_q.marked | (32'd1 << m_bit);
      end
      ST_W_SRD: s_ra = SAW'(cnt);
      ST_W_SWR: begin
        s_we = 1'b1;
        s_wa = SAW'(cnt);
        s_wd.used   = s_q.marked;
        s_wd.marked = 32'd0;
      end
      ST_W_BRD: b_ra = BAW'(cnt);
      ST_W_BWR: begin
        b_we = 1'b1;
        b_wa = BAW'(cnt);
        b_wd.used   = b_q.used & sw_keep;
        b_wd.start  = b_q.start & b_q.marked;
        b_wd.marked = 32'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_we) smem[s_wa] <= s_wd;
    if (b_we) bmem[b_wa] <= b_wd;
    s_q <= smem[s_ra];
    b_q <= bmem[b_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= ST_CLEAR;
      cnt    <= '0;
      done   <= 1'b0;
      base8  <= '0;
      base16 <= '0;
      base32 <= '0;
      basegr <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          REG_BASE8:  base8  <= cfg_data;
          REG_BASE16: base16 <= cfg_data;
          REG_BASE32: base32 <= cfg_data;
          REG_BASEGR: basegr <= cfg_data;
          default: ;
        endcase
      end
      case (st)
        ST_CLEAR: begin
          if (32'(cnt) == CMAX - 1) st <= ST_IDLE;
          else cnt <= cnt + CW'(1);
        end
        ST_IDLE: begin
          if (start) begin
            addr_r  <= address;
            sw      <= '0;
            bw      <= '0;
            run_len <= '0;
            cnt     <= '0;
            carry   <= 1'b0;
            need    <= (need_c == '0) ? NEED_W'(1) : need_c;
            cls     <= (length_bytes <= 16'd8) ? 2'd0 : (length_bytes <= 16'd16) ? 2'd1 : 2'd2;
            case (kind)
              KIND_ALLOC: st <= (length_bytes <= 16'd32) ? ST_S_RD : ST_B_RD;
              KIND_MARK:  st <= ST_M_DEC;
              KIND_SWEEP: st <= ST_W_SRD;
              default: begin
                done           <= 1'b1;
                status         <= 1'b1;
                result_address <= '0;
              end
            endcase
          end
        end
        ST_S_RD: st <= ST_S_CHK;
        ST_S_CHK: begin
          if (~s_uw != 32'd0) begin
            done           <= 1'b1;
            status         <= 1'b0;
            result_address <= ((cls == 2'd0) ? base8 : (cls == 2'd1) ? base16 : base32) +
                              (32'({sw, s_k}) << (5'd3 + 5'(cls)));
            st             <= ST_IDLE;
          end else if (32'(sw) == SW - 1) begin
            sw <= '0;
            if (cls == 2'd2) st <= ST_B_RD;
            else begin
              cls <= cls + 2'd1;
              st  <= ST_S_RD;
            end
          end else begin
            sw <= sw + SWW'(1);
            st <= ST_S_RD;
          end
        end
        ST_B_RD: begin
          if (32'(need) > BIG_GRANULES) begin
            done           <= 1'b1;
            status         <= 1'b1;
            result_address <= '0;
            st             <= ST_IDLE;
          end else st <= ST_B_CHK;
        end
        ST_B_CHK: begin
          if (b_uw == 32'd0 && len_plus32 >= {1'b0, need}) begin
            e_beg <= (run_len == '0) ? word_start : run_start;
            e_end <= ((run_len == '0) ? word_start : run_start) + GW'(need - NEED_W'(1));
            bw    <= (run_len == '0) ? bw : BAW'(run_start >> 5);
            st    <= ST_B_SRD;
          end else if (b_uw == 32'd0) begin
            if (run_len == '0) run_start <= word_start;
            run_len <= run_len + NEED_W'(32);
            if (32'(bw) == BW - 1) begin
              done <= 1'b1; status <= 1'b1; result_address <= '0; st <= ST_IDLE;
            end else begin
              bw <= bw + BAW'(1);
              st <= ST_B_RD;
            end
          end else if (b_uw == 32'hffff_ffff) begin
            run_len <= '0;
            if (32'(bw) == BW - 1) begin
              done <= 1'b1; status <= 1'b1; result_address <= '0; st <= ST_IDLE;
            end else begin
              bw <= bw + BAW'(1);
              st <= ST_B_RD;
            end
          end else begin
            hold <= b_uw;
            bk   <= 5'd0;
            st   <= ST_B_BIT;
          end
        end
        ST_B_BIT: begin
          if (!hold[bk] && len_plus1 >= {1'b0, need}) begin
            e_beg <= (run_len == '0) ? bit_pos : run_start;
            e_end <= ((run_len == '0) ? bit_pos : run_start) + GW'(need - NEED_W'(1));
            bw    <= (run_len == '0) ? bw : BAW'(run_start >> 5);
            st    <= ST_B_SRD;
          end else begin
            if (hold[bk]) run_len <= '0;
            else begin
              if (run_len == '0) run_start <= bit_pos;
              run_len <= run_len + NEED_W'(1);
            end
            if (bk == 5'd31) begin
              if (32'(bw) == BW - 1) begin
                done <= 1'b1; status <= 1'b1; result_address <= '0; st <= ST_IDLE;
              end else begin
                bw <= bw + BAW'(1);
                st <= ST_B_RD;
              end
            end else bk <= bk + 5'd1;
          end
        end
        ST_B_SRD: st <= ST_B_SWR;
        ST_B_SWR: begin
          if (bw == end_bw) begin
            done           <= 1'b1;
            status         <= 1'b0;
            result_address <= basegr + (32'(e_beg) << GRANULE_LOG);
            st             <= ST_IDLE;
          end else begin
            bw <= bw + BAW'(1);
            st <= ST_B_SRD;
          end
        end
        ST_M_DEC: begin
          m_big <= (msel == 2'd3);
          m_swa <= dec_swa;
          m_bwa <= dec_bwa;
          m_bit <= midx[4:0];
          if (mhit && maligned) st <= ST_M_CHK;
          else begin
            done <= 1'b1; status <= 1'b1; result_address <= '0; st <= ST_IDLE;
          end
        end
        ST_M_CHK: begin
          done           <= 1'b1;
          result_address <= '0;
          status         <= m_big ? !(b_q.used[m_bit] && b_q.start[m_bit]) : !s_q.used[m_bit];
          st             <= ST_IDLE;
        end
        ST_W_SRD: st <= ST_W_SWR;
        ST_W_SWR: begin
          if (32'(cnt) == SDEPTH - 1) cnt <= '0;
          else cnt <= cnt + CW'(1);
          st <= (32'(cnt) == SDEPTH - 1) ? ST_W_BRD : ST_W_SRD;
        end
        ST_W_BRD: st <= ST_W_BWR;
        ST_W_BWR: begin
          carry <= sw_keep[31];
          if (32'(cnt) == BW - 1) begin
            done <= 1'b1; status <= 1'b0; result_address <= '0; st <= ST_IDLE;
          end else begin
            cnt <= cnt + CW'(1);
            st  <= ST_W_BRD;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result without a transfer or work in progress");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (kind == KIND_ALLOC || kind == KIND_MARK || kind == KIND_SWEEP))
      |=> busy)
    else $error("accepted transfer did not raise busy");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (result_address == '0))
    else $error("failed transfer with nonzero address");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result while still busy");
`endif

endmodule

FILE: tb/sv/bitmap_heap_alloc_mark_sweep_unit_tb.sv
// testbench for bitmap_heap_alloc_mark_sweep_unit: directed and random allocate,
// mark and sweep traffic checked against an in-bench heap bookkeeping predictor.
// depends on bhams_pkg and the unit itself.
module bitmap_heap_alloc_mark_sweep_unit_tb;
  import bhams_pkg::*;

  localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;
  localparam int NSLOT = SMALL_SLOTS_DEF;
  localparam int NGRAN = BIG_GRANULES_DEF;
  localparam int GLOG  = GRANULE_LOG_DEF;

  typedef struct {
    logic [KIND_W-1:0] op;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] addr;
  } heap_req_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic              st;
  } heap_resp_t;

  logic clk, rst, start, busy, cfg_write, done, status;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  logic [KIND_W-1:0] kind;
  logic [LEN_W-1:0] length_bytes;
  logic [ADDR_W-1:0] address, result_address;

  bitmap_heap_alloc_mark_sweep_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .kind(kind), .length_bytes(length_bytes), .address(address),
    .done(done), .result_address(result_address), .status(status)
  );

  // predictor state
  logic [31:0] base_reg [0:3];
  bit sm_used [0:3*NSLOT-1];
  bit sm_mark [0:3*NSLOT-1];
  bit gr_used [0:NGRAN-1];
  bit gr_mark [0:NGRAN-1];
  bit gr_start [0:NGRAN-1];
  bit keep_run;

  heap_req_t pending_ops[$];
  heap_resp_t expected_results[$];
  logic [31:0] live_addrs[$];
  int n_items = 0, n_checked = 0, n_errors = 0;
  int burst_left, gap_left;

  function automatic bit take_slot(input int unsigned len, output logic [31:0] a);
    int unsigned size;
    for (int c = 0; c < 3; c++) begin
      size = 8 << c;
      if (size < len) continue;
      for (int s = 0; s < NSLOT; s++) begin
        if (!sm_used[c*NSLOT+s]) begin
          sm_used[c*NSLOT+s] = 1;
          a = base_reg[c] + size * s;
          return 1;
        end
      end
    end
    return 0;
  endfunction

  function automatic bit take_run(input int unsigned len, output logic [31:0] a);
    int unsigned need, run, first;
    need = (len + (1 << GLOG) - 1) >> GLOG;
    if (need == 0) need = 1;
    if (need > NGRAN) return 0;
    run = 0;
    for (int i = 0; i < NGRAN; i++) begin
      if (gr_used[i]) run = 0;
      else begin
        run++;
        if (run >= need) begin
          first = i - need + 1;
          for (int j = first; j <= i; j++) gr_used[j] = 1;
          gr_start[first] = 1;
          a = base_reg[3] + (first << GLOG);
          return 1;
        end
      end
    end
    return 0;
  endfunction

  function automatic bit mark_obj(input logic [31:0] a);
    logic [31:0] off;
    int unsigned lg, idx;
    longint unsigned cnt;
    for (int r = 0; r < 4; r++) begin
      lg  = (r < 3) ? 3 + r : GLOG;
      cnt = (r < 3) ? NSLOT : NGRAN;
      if (a < base_reg[r]) continue;
      off = a - base_reg[r];
      if (64'(off) >= (cnt << lg)) continue;
      if ((off & ((32'd1 << lg) - 1)) != 0) return 0;
      idx = off >> lg;
      if (r < 3) begin
        if (!sm_used[r*NSLOT+idx]) return 0;
        sm_mark[r*NSLOT+idx] = 1;
      end else begin
        if (!gr_used[idx] || !gr_start[idx]) return 0;
        gr_mark[idx] = 1;
      end
      return 1;
    end
    return 0;
  endfunction

  function automatic void sweep_heap();
    for (int i = 0; i < 3*NSLOT; i++) begin
      sm_used[i] = sm_mark[i];
      sm_mark[i] = 0;
    end
    keep_run = 0;
    for (int i = 0; i < NGRAN; i++) begin
      if (gr_start[i]) begin
        keep_run = gr_mark[i];
        if (!keep_run) gr_start[i] = 0;
      end
      if (!keep_run) gr_used[i] = 0;
    end
    for (int i = 0; i < NGRAN; i++) gr_mark[i] = 0;
  endfunction

  function automatic heap_resp_t heap_apply(input heap_req_t r);
    heap_resp_t o;
    bit ok;
    o.addr = 0;
    o.st = 1;
    case (r.op)
      KIND_ALLOC: begin
        ok = 0;
        if (r.len <= 32) ok = take_slot(32'(r.len), o.addr);
        if (!ok) ok = take_run(32'(r.len), o.addr);
        if (ok) begin
          o.st = 0;
          live_addrs.push_back(o.addr);
          if (live_addrs.size() > 96) void'(live_addrs.pop_front());
        end else o.addr = 0;
      end
      KIND_MARK: o.st = !mark_obj(r.addr);
      KIND_SWEEP: begin
        sweep_heap();
        o.st = 0;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic heap_req_t mk_req(logic [KIND_W-1:0] op, int unsigned len,
                                       logic [ADDR_W-1:0] a);
    heap_req_t r;
    r.op = op;
    r.len = LEN_W'(len);
    r.addr = a;
    return r;
  endfunction

  function automatic heap_req_t rand_req();
    int p;
    logic [31:0] a;
    p = $urandom_range(0, 99);
    if (p < 40) return mk_req(KIND_ALLOC, $urandom_range(0, 32), $urandom());
    if (p < 58) begin
      if ($urandom_range(0, 19) == 0) return mk_req(KIND_ALLOC, $urandom(), $urandom());
      return mk_req(KIND_ALLOC, $urandom_range(33, 1024), $urandom());
    end
    if (p < 84) begin
      if (live_addrs.size() > 0 && $urandom_range(0, 99) < 85) begin
        a = live_addrs[$urandom_range(0, live_addrs.size()-1)];
        if ($urandom_range(0, 5) == 0) a = a + $urandom_range(1, 7);
      end else a = $urandom();
      return mk_req(KIND_MARK, $urandom(), a);
    end
    if (p < 95) return mk_req(KIND_SWEEP, $urandom(), $urandom());
    return mk_req(KIND_BAD, $urandom(), $urandom());
  endfunction

  initial clk = 0;
  always #2 clk = ~clk;

  // driver: holds start until the transfer, then bursts and gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 0;
      kind <= KIND_ALLOC;
      length_bytes <= '0;
      address <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(heap_apply(pending_ops.pop_front()));
        n_items++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 0;
        end else if (pending_ops.size() > 0) begin
          start <= 1;
          kind <= pending_ops[0].op;
          length_bytes <= pending_ops[0].len;
          address <= pending_ops[0].addr;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            case ($urandom_range(0, 9))
              0, 1, 2: gap_left <= 0;
              8, 9: gap_left <= $urandom_range(30, 200);
              default: gap_left <= $urandom_range(1, 12);
            endcase
          end else burst_left <= burst_left - 1;
        end else start <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result addr=%h status=%b", $time, result_address, status);
        n_errors++;
      end else begin
        heap_resp_t e;
        e = expected_results.pop_front();
        n_checked++;
        if (result_address !== e.addr) begin
          $display("%0t result_address expected %h actual %h", $time, e.addr,
                   result_address);
          n_errors++;
        end
        if (status !== e.st) begin
          $display("%0t status expected %b actual %b", $time, e.st, status);
          n_errors++;
        end
      end
    end
  end

  task automatic drain();
    while (pending_ops.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_bases(logic [31:0] b8, logic [31:0] b16, logic [31:0] b32,
                           logic [31:0] bg);
    logic [31:0] v [0:3];
    logic [1:0] idx [0:3];
    v = '{b8, b16, b32, bg};
    idx = '{REG_BASE8, REG_BASE16, REG_BASE32, REG_BASEGR};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_write <= 1;
      cfg_index <= idx[i];
      cfg_data <= v[i];
      base_reg[idx[i]] = v[i];
    end
    @(posedge clk);
    cfg_write <= 0;
  endtask

  task automatic run_random(int n);
    int left;
    left = n;
    while (left > 0) begin
      for (int i = 0; i < 25 && left > 0; i++, left--) pending_ops.push_back(rand_req());
      while (pending_ops.size() != 0) @(posedge clk);
    end
  endtask

  initial begin
    rst = 1;
    cfg_write = 0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < 4; i++) base_reg[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // clearing pass after reset
    while (busy) @(posedge clk);

    set_bases(32'h1000, 32'h2000, 32'h4000, 32'h10000);
    pending_ops.push_back(mk_req(KIND_ALLOC, 0, 0));
    pending_ops.push_back(mk_req(KIND_ALLOC, 8, 0));
    pending_ops.push_back(mk_req(KIND_ALLOC, 9, 0));
    pending_ops.push_back(mk_req(KIND_ALLOC, 17, 0));
    pending_ops.push_back(mk_req(KIND_ALLOC, 32, 0));
    pending_ops.push_back(mk_req(KIND_ALLOC, 33, 0));
    pending_ops.push_back(mk_req(KIND_ALLOC, 32768, 0));
    pending_ops.push_back(mk_req(KIND_ALLOC, 65535, 32'hffffffff));
    pending_ops.push_back(mk_req(KIND_ALLOC, 100, 0));
    pending_ops.push_back(mk_req(KIND_MARK, 0, 32'h1000));
    pending_ops.push_back(mk_req(KIND_MARK, 0, 32'h1004));
    pending_ops.push_back(mk_req(KIND_MARK, 0, 32'h1010));
    pending_ops.push_back(mk_req(KIND_MARK, 0, 32'h10000));
    pending_ops.push_back(mk_req(KIND_MARK, 0, 32'h10020));
    pending_ops.push_back(mk_req(KIND_MARK, 0, 32'h0));
    pending_ops.push_back(mk_req(KIND_MARK, 0, 32'hffffffff));
    pending_ops.push_back(mk_req(KIND_SWEEP, 65535, 0));
    pending_ops.push_back(mk_req(KIND_BAD, 65535, 32'hffffffff));
    pending_ops.push_back(mk_req(KIND_MARK, 0, 32'h1008));
    pending_ops.push_back(mk_req(KIND_ALLOC, 0, 0));
    pending_ops.push_back(mk_req(KIND_MARK, 0, 32'h10040));
    pending_ops.push_back(mk_req(KIND_SWEEP, 0, 0));
    // fill the 8-byte class so allocation falls through to the larger small classes
    for (int i = 0; i < 300; i++)
      pending_ops.push_back(mk_req(KIND_ALLOC, $urandom_range(0, 8), $urandom()));
    drain();
    run_random(300);
    drain();

    // all regions overlapping at zero
    set_bases(32'h0, 32'h0, 32'h0, 32'h0);
    run_random(250);
    drain();

    // bases near the top so addresses wrap
    set_bases(32'hffffffff, 32'hfffff800, 32'hfffffff0, 32'hffff8000);
    run_random(250);
    drain();

    set_bases($urandom(), $urandom(), $urandom(), $urandom());
    run_random(300);
    drain();
    repeat (50) @(posedge clk);

    $display("ran %0d operations over 4 base settings, %0d results checked, %0d errors",
             n_items, n_checked, n_errors);
    if (n_errors == 0 && expected_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #40000000;
    $display("timeout after %0t", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/bhams_pkg.sv
rtl/core/bitmap_heap_alloc_mark_sweep_unit.sv
tb/sv/bitmap_heap_alloc_mark_sweep_unit_tb.sv
